FILE: hdl/error_diffusion_dither_core_assert.svh
// Assertion macros for the error diffusion dither core.
// Included by the top level; expects clk and rst_n in scope.
`ifndef ERROR_DIFFUSION_DITHER_CORE_ASSERT_SVH
`define ERROR_DIFFUSION_DITHER_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define EDD_ASSERT_IMP(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("edd: same-cycle check failed");
`define EDD_ASSERT_NEXT(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("edd: next-cycle check failed");
`else
`define EDD_ASSERT_IMP(label, a, b)
`define EDD_ASSERT_NEXT(label, a, b)
`endif
`endif

FILE: hdl/edd_pkg.sv
// Shared types, constants and helpers for the error diffusion dither core.
// No dependencies.
package edd_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int CFG_W      = 11;
    localparam int CFG_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int PIX_W      = 8;
    localparam int ERR_W      = 8;
    localparam int SUM_W      = 18;
    localparam int RECIP_W    = 19;
    localparam int GRAY_SHIFT = 28;
    localparam int SHARE_W    = 11;

    // compare width: holds a counter + 1 and any limit value
    localparam int CMP_A  = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int CMP_W  = ((CMP_A > CFG_W) ? CMP_A : CFG_W) + 2;

    localparam logic [SUM_W-1:0] COEF_R    = SUM_W'(299);
    localparam logic [SUM_W-1:0] COEF_G    = SUM_W'(587);
    localparam logic [SUM_W-1:0] COEF_B    = SUM_W'(114);
    localparam logic [SUM_W-1:0] GRAY_RND  = SUM_W'(500);
    // ceil(2^28 / 1000), exact floor division for sums below 2^18
    localparam logic [RECIP_W-1:0] GRAY_RECIP = RECIP_W'(268436);

    localparam logic [CFG_W-1:0] LINE_WIDTH_RST   = CFG_W'(640);
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = CFG_W'(480);

    typedef enum logic {
        REG_LINE_WIDTH,
        REG_FRAME_HEIGHT
    } reg_idx_t;

    typedef struct packed {
        logic             has_left;
        logic             has_up;
        logic             last_col;
        logic             last_row;
        logic [COL_W-1:0] col;
    } pos_t;

    // 0 acts as 1, anything above the maximum acts as the maximum
    function automatic logic [CMP_W-1:0] limit_dim(input logic [CMP_W-1:0] v,
                                                   input logic [CMP_W-1:0] max_v);
        logic [CMP_W-1:0] r;
        if (v == '0)
            r = CMP_W'(1);
        else if (v > max_v)
            r = max_v;
        else
            r = v;
        return r;
    endfunction

endpackage

FILE: hdl/error_diffusion_dither_core.sv
// Top level of the error diffusion dither core.
// Depends on edd_pkg, edd_apb_regs, edd_line_buf, edd_diffuse and the assert header.
//
// Usage:
//   Input channel (in_valid/in_ready, red/green/blue) takes RGB pixels in raster
//   order; output channel (out_valid/out_ready, white/frame_end) gives one bit per
//   pixel, frame_end on the last pixel of a frame. line_width and frame_height are
//   set over the APB port (0x0 and 0x4) while the core is idle.
//   A request accepted into the input register reaches the output from the result
//   register. Throughput: one pixel per clock while out_ready is high, bound by
//   the left-error feedback loop, which closes through the diffusion datapath.
//   The weighted RGB sum is formed at the input register; the divide by 1000 and
//   the three clamped adds sit between the input and result registers. The
//   previous-row error line is a 1024x8 memory read by column as a pixel is accepted.
//   Reset: position counters and carried errors clear, registers go to 640x480;
//   the line memory is not cleared (row 0 never reads it).
//   Stall: when out_ready is low the result register holds, one more request is
//   taken into the input register, and in_ready then drops until the output moves.
module error_diffusion_dither_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [edd_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [edd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [edd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [edd_pkg::PIX_W-1:0]        red,
    input  logic [edd_pkg::PIX_W-1:0]        green,
    input  logic [edd_pkg::PIX_W-1:0]        blue,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             white,
    output logic                             frame_end
);
    import edd_pkg::*;

    `include "error_diffusion_dither_core_assert.svh"

    logic [CFG_W-1:0]        line_width;
    logic [CFG_W-1:0]        frame_height;
    logic [CMP_W-1:0]        w_eff;
    logic [CMP_W-1:0]        h_eff;

    logic [COL_W-1:0]        col_reg;
    logic [ROW_W-1:0]        row_reg;
    pos_t                    pos_cur;
    logic                    accept;

    logic                    s1_valid_reg;
    logic [SUM_W-1:0]        s1_sum_reg;
    pos_t                    s1_pos_reg;
    logic                    s1_adv;
    logic [SUM_W-1:0]        sum_in;

    logic signed [ERR_W-1:0] upper;
    logic signed [ERR_W-1:0] left_reg;
    logic signed [ERR_W-1:0] upper_left_reg;
    logic                    white_c;
    logic signed [ERR_W-1:0] err_c;

    logic                    out_valid_reg;
    logic                    white_reg;
    logic                    frame_end_reg;

    edd_apb_regs u_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .line_width   (line_width),
        .frame_height (frame_height)
    );

    assign w_eff = limit_dim(CMP_W'(line_width), CMP_W'(MAX_WIDTH));
    assign h_eff = limit_dim(CMP_W'(frame_height), CMP_W'(MAX_HEIGHT));

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        pos_cur.has_left = (col_reg != '0);
        pos_cur.has_up   = (row_reg != '0);
        pos_cur.last_col = (CMP_W'(col_reg) + CMP_W'(1)) >= w_eff;
        pos_cur.last_row = (CMP_W'(row_reg) + CMP_W'(1)) >= h_eff;
        pos_cur.col      = col_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            if (pos_cur.last_col)
            begin
                col_reg <= '0;
                row_reg <= pos_cur.last_row ? '0 : ROW_W'(row_reg + ROW_W'(1));
            end
            else
                col_reg <= COL_W'(col_reg + COL_W'(1));
        end
    end

    // weighted sum plus rounding term; constant multiplies only
    assign sum_in = SUM_W'(red) * COEF_R + SUM_W'(green) * COEF_G
                  + SUM_W'(blue) * COEF_B + GRAY_RND;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (accept)
            s1_valid_reg <= 1'b1;
        else if (s1_adv)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sum_reg <= sum_in;
            s1_pos_reg <= pos_cur;
        end
    end

    edd_line_buf u_line (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .wr_en   (s1_adv),
        .wr_addr (s1_pos_reg.col),
        .wr_data (err_c),
        .rd_data (upper)
    );

    edd_diffuse u_diffuse (
        .sum        (s1_sum_reg),
        .pos        (s1_pos_reg),
        .upper      (upper),
        .upper_left (upper_left_reg),
        .left       (left_reg),
        .white      (white_c),
        .err        (err_c)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg       <= '0;
            upper_left_reg <= '0;
        end
        else if (s1_adv)
        begin
            left_reg       <= err_c;
            upper_left_reg <= upper;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_adv)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            white_reg     <= white_c;
            frame_end_reg <= s1_pos_reg.last_col && s1_pos_reg.last_row;
        end
    end

    assign out_valid = out_valid_reg;
    assign white     = white_reg;
    assign frame_end = frame_end_reg;

    `EDD_ASSERT_IMP(a_take_implies_drain, accept && s1_valid_reg, s1_adv)
    `EDD_ASSERT_NEXT(a_adv_fills_out, s1_adv, out_valid_reg)
    `EDD_ASSERT_IMP(a_frame_wrap, s1_valid_reg && s1_pos_reg.last_col && s1_pos_reg.last_row,
                    col_reg == '0 && row_reg == '0)

endmodule

FILE: hdl/edd_apb_regs.sv
// APB configuration registers: line width and frame height.
// Depends on edd_pkg.
module edd_apb_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [edd_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [edd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [edd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    output logic [edd_pkg::CFG_W-1:0]        line_width,
    output logic [edd_pkg::CFG_W-1:0]        frame_height
);
    import edd_pkg::*;

    logic [CFG_W-1:0] line_width_reg;
    logic [CFG_W-1:0] frame_height_reg;
    logic             wr_en;
    reg_idx_t         idx;

    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1]);
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg   <= LINE_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_LINE_WIDTH:   line_width_reg   <= pwdata[CFG_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= pwdata[CFG_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_LINE_WIDTH:   prdata = APB_DATA_W'(line_width_reg);
            REG_FRAME_HEIGHT: prdata = APB_DATA_W'(frame_height_reg);
            default:          prdata = '0;
        endcase
    end

    assign line_width   = line_width_reg;
    assign frame_height = frame_height_reg;

endmodule

FILE: hdl/edd_line_buf.sv
// Previous-row error memory with one registered read port and a
// same-edge write bypass. Depends on edd_pkg.
module edd_line_buf (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           rd_en,
    input  logic [edd_pkg::COL_W-1:0]      rd_addr,
    input  logic                           wr_en,
    input  logic [edd_pkg::COL_W-1:0]      wr_addr,
    input  logic signed [edd_pkg::ERR_W-1:0] wr_data,
    output logic signed [edd_pkg::ERR_W-1:0] rd_data
);
    import edd_pkg::*;

    logic signed [ERR_W-1:0] mem [MAX_WIDTH];
    logic signed [ERR_W-1:0] rd_data_reg;
    logic signed [ERR_W-1:0] byp_data_reg;
    logic                    byp_hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
        begin
            rd_data_reg  <= mem[rd_addr];
            byp_data_reg <= wr_data;
        end
    end

    // read and write of one column at the same edge: take the new value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            byp_hit_reg <= 1'b0;
        else if (rd_en)
            byp_hit_reg <= wr_en && (wr_addr == rd_addr);
    end

    assign rd_data = byp_hit_reg ? byp_data_reg : rd_data_reg;

endmodule

FILE: hdl/edd_diffuse.sv
// Per-pixel datapath: gray divide, three clamped error shares, threshold.
// Depends on edd_pkg.
module edd_diffuse (
    input  logic [edd_pkg::SUM_W-1:0]        sum,
    input  edd_pkg::pos_t                    pos,
    input  logic signed [edd_pkg::ERR_W-1:0] upper,
    input  logic signed [edd_pkg::ERR_W-1:0] upper_left,
    input  logic signed [edd_pkg::ERR_W-1:0] left,
    output logic                             white,
    output logic signed [edd_pkg::ERR_W-1:0] err
);
    import edd_pkg::*;

    localparam int MUL_W = SUM_W + RECIP_W;

    logic [MUL_W-1:0]          gray_prod;
    logic [PIX_W-1:0]          gray;
    logic signed [SHARE_W-1:0] sh_ul;
    logic signed [SHARE_W-1:0] sh_up;
    logic signed [SHARE_W-1:0] sh_left;
    logic [PIX_W-1:0]          v1;
    logic [PIX_W-1:0]          v2;
    logic [PIX_W-1:0]          v3;

    function automatic logic signed [SHARE_W-1:0] ext(input logic signed [ERR_W-1:0] e);
        return {{(SHARE_W-ERR_W){e[ERR_W-1]}}, e};
    endfunction

    // floor(e/4 + 0.5)
    function automatic logic signed [SHARE_W-1:0] share_q(input logic signed [ERR_W-1:0] e);
        logic signed [SHARE_W-1:0] t;
        t = ext(e) + SHARE_W'(2);
        return t >>> 2;
    endfunction

    // floor(3e/8 + 0.5)
    function automatic logic signed [SHARE_W-1:0] share_te(input logic signed [ERR_W-1:0] e);
        logic signed [SHARE_W-1:0] t;
        t = (ext(e) <<< 1) + ext(e) + SHARE_W'(4);
        return t >>> 3;
    endfunction

    function automatic logic [PIX_W-1:0] add_clamp(input logic [PIX_W-1:0] v,
                                                   input logic signed [SHARE_W-1:0] s);
        logic signed [SHARE_W:0] r;
        r = $signed({{(SHARE_W+1-PIX_W){1'b0}}, v}) + {s[SHARE_W-1], s};
        if (r > $signed((SHARE_W+1)'(255)))
            return PIX_W'(255);
        else if (r < 0)
            return '0;
        else
            return r[PIX_W-1:0];
    endfunction

    assign gray_prod = MUL_W'(sum) * MUL_W'(GRAY_RECIP);
    assign gray      = gray_prod[GRAY_SHIFT +: PIX_W];

    assign sh_ul   = share_q(upper_left);
    assign sh_up   = share_te(upper);
    assign sh_left = share_te(left);

    assign v1 = (pos.has_left && pos.has_up) ? add_clamp(gray, sh_ul) : gray;
    assign v2 = pos.has_up ? add_clamp(v1, sh_up) : v1;
    assign v3 = pos.has_left ? add_clamp(v2, sh_left) : v2;

    assign white = v3[PIX_W-1];
    // v - 255 wraps to the right 8-bit signed value for white pixels
    assign err   = white ? $signed(ERR_W'(v3 - PIX_W'(255))) : $signed(v3);

endmodule

FILE: dv/tb_error_diffusion_dither_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for error_diffusion_dither_core: RGB pixel stream in, dithered bits out.
// Depends on edd_pkg and the core RTL; the predictor is written locally from the pixel math.
module tb_error_diffusion_dither_core;
    import edd_pkg::*;

    typedef struct packed {
        logic white;
        logic frame_end;
    } dither_bit_t;

    typedef struct packed {
        logic [PIX_W-1:0] r;
        logic [PIX_W-1:0] g;
        logic [PIX_W-1:0] b;
    } rgb_t;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr     = '0;
    logic [APB_DATA_W-1:0] pwdata    = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic [PIX_W-1:0]      red       = '0;
    logic [PIX_W-1:0]      green     = '0;
    logic [PIX_W-1:0]      blue      = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  white;
    logic                  frame_end;

    error_diffusion_dither_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .white     (white),
        .frame_end (frame_end)
    );

    // predictor state: previous-row errors, carried errors, raster position, geometry
    logic signed [ERR_W-1:0] row_err [MAX_WIDTH];
    logic signed [ERR_W-1:0] left_err;
    logic signed [ERR_W-1:0] up_left_err;
    int                      col_pos;
    int                      row_pos;
    logic [CFG_W-1:0]        cur_width;
    logic [CFG_W-1:0]        cur_height;

    dither_bit_t expected_bits[$];
    int          mismatches  = 0;
    int          pixel_count = 0;
    int          frame_count = 0;
    int          geom_count  = 0;
    bit          idle_en     = 1'b1;
    int          stall_left  = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(5_000_000);
        $display("%0t: timeout, %0d results still pending", $time, expected_bits.size());
        $display("error_diffusion_dither_core regression: fail");
        $finish;
    end

    function automatic int eff_dim(logic [CFG_W-1:0] v, int max_v);
        if (v == '0)
            return 1;
        if (int'(v) > max_v)
            return max_v;
        return int'(v);
    endfunction

    function automatic int add_sat(int v, int s);
        int r;
        r = v + s;
        if (r > 255)
            return 255;
        if (r < 0)
            return 0;
        return r;
    endfunction

    // a wider row mid-frame would read entries the previous row never wrote
    function automatic bit width_change_ok(logic [CFG_W-1:0] v);
        return row_pos == 0 || eff_dim(v, MAX_WIDTH) <= eff_dim(cur_width, MAX_WIDTH);
    endfunction

    function automatic int pixels_to_frame_end();
        int w;
        int h;
        int cols_left;
        w = eff_dim(cur_width, MAX_WIDTH);
        h = eff_dim(cur_height, MAX_HEIGHT);
        cols_left = (col_pos + 1 >= w) ? 1 : w - col_pos;
        if (row_pos + 1 >= h)
            return cols_left;
        return cols_left + (h - 1 - row_pos) * w;
    endfunction

    function automatic rgb_t random_pixel();
        rgb_t px;
        logic [PIX_W-1:0] x;
        px.r = PIX_W'($urandom);
        px.g = PIX_W'($urandom);
        px.b = PIX_W'($urandom);
        case ($urandom_range(0, 5))
            3:
            begin
                // gray close to the threshold
                x = PIX_W'($urandom_range(96, 160));
                px = {x, x, x};
            end
            4:
            begin
                px.r = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                px.g = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                px.b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
            5:
            begin
                x = PIX_W'($urandom);
                px = '0;
                case ($urandom_range(0, 2))
                    0: px.r = x;
                    1: px.g = x;
                    default: px.b = x;
                endcase
            end
            default: ;
        endcase
        return px;
    endfunction

    task automatic diffuse_pixel(rgb_t px);
        int          w;
        int          h;
        int          v;
        int          up;
        int          ul;
        int          lf;
        int          err;
        logic        has_left;
        logic        has_up;
        logic        last_col;
        logic        last_row;
        dither_bit_t d;
        w = eff_dim(cur_width, MAX_WIDTH);
        h = eff_dim(cur_height, MAX_HEIGHT);
        has_left = col_pos != 0;
        has_up   = row_pos != 0;
        last_col = col_pos + 1 >= w;
        last_row = row_pos + 1 >= h;
        up = (col_pos < MAX_WIDTH) ? int'(row_err[col_pos]) : 0;
        ul = int'(up_left_err);
        lf = int'(left_err);

        v = (299 * int'(px.r) + 587 * int'(px.g) + 114 * int'(px.b) + 500) / 1000;
        if (has_left && has_up)
            v = add_sat(v, (ul + 2) >>> 2);
        if (has_up)
            v = add_sat(v, (3 * up + 4) >>> 3);
        if (has_left)
            v = add_sat(v, (3 * lf + 4) >>> 3);

        d.white = v > 127;
        err = d.white ? v - 255 : v;
        d.frame_end = last_col && last_row;

        up_left_err = ERR_W'(up);
        if (col_pos < MAX_WIDTH)
            row_err[col_pos] = ERR_W'(err);
        left_err = ERR_W'(err);

        if (last_col)
        begin
            col_pos = 0;
            row_pos = last_row ? 0 : row_pos + 1;
        end
        else
            col_pos = col_pos + 1;

        if (d.frame_end)
            frame_count++;
        expected_bits.push_back(d);
    endtask

    task automatic send_pixel(rgb_t px);
        if (idle_en && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        red      <= px.r;
        green    <= px.g;
        blue     <= px.b;
        do @(posedge clk); while (!in_ready);
        diffuse_pixel(px);
        pixel_count++;
    endtask

    task automatic send_rgb(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g, logic [PIX_W-1:0] b);
        send_pixel({r, g, b});
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_bits.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic check_reg(reg_idx_t idx, logic [CFG_W-1:0] val);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata[CFG_W-1:0] !== val)
        begin
            $display("%0t: reg %s readback expected %0d got %0d",
                     $time, idx.name(), val, prdata[CFG_W-1:0]);
            mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_reg(reg_idx_t idx, int val);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= APB_DATA_W'(val);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_LINE_WIDTH)
            cur_width = CFG_W'(val);
        else
            cur_height = CFG_W'(val);
        geom_count++;
        @(posedge clk);
        check_reg(idx, CFG_W'(val));
    endtask

    // result side: compare against the oldest pending bit, random backpressure
    always @(posedge clk)
    begin
        dither_bit_t exp_bit;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_bits.size() == 0)
                begin
                    $display("%0t: result with no pixel pending (white %0b frame_end %0b)",
                             $time, white, frame_end);
                    mismatches++;
                end
                else
                begin
                    exp_bit = expected_bits.pop_front();
                    if (white !== exp_bit.white)
                    begin
                        $display("%0t: white expected %0b got %0b", $time, exp_bit.white, white);
                        mismatches++;
                    end
                    if (frame_end !== exp_bit.frame_end)
                    begin
                        $display("%0t: frame_end expected %0b got %0b",
                                 $time, exp_bit.frame_end, frame_end);
                        mismatches++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if (idle_en && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                stall_left = $urandom_range(0, 3);
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic test_directed();
        int n;
        check_reg(REG_LINE_WIDTH, LINE_WIDTH_RST);
        check_reg(REG_FRAME_HEIGHT, FRAME_HEIGHT_RST);

        // row 0 of the reset geometry: channel extremes and the threshold
        send_rgb(8'd0, 8'd0, 8'd0);
        send_rgb(8'd255, 8'd255, 8'd255);
        send_rgb(8'd255, 8'd0, 8'd0);
        send_rgb(8'd0, 8'd255, 8'd0);
        send_rgb(8'd0, 8'd0, 8'd255);
        send_rgb(8'd127, 8'd127, 8'd127);
        send_rgb(8'd128, 8'd128, 8'd128);
        send_rgb(8'd255, 8'd255, 8'd0);
        wait_idle();

        // column counter already past the new width: wraps on the next pixel
        set_reg(REG_LINE_WIDTH, 4);
        set_reg(REG_FRAME_HEIGHT, 2);
        send_rgb(8'd90, 8'd200, 8'd10);
        send_rgb(8'd255, 8'd255, 8'd255);
        send_rgb(8'd0, 8'd0, 8'd0);
        send_rgb(8'd200, 8'd200, 8'd200);
        send_rgb(8'd60, 8'd60, 8'd60);
        wait_idle();

        // one-pixel frames
        set_reg(REG_LINE_WIDTH, 1);
        set_reg(REG_FRAME_HEIGHT, 1);
        send_rgb(8'd128, 8'd128, 8'd128);
        send_rgb(8'd127, 8'd127, 8'd127);
        send_rgb(8'd0, 8'd0, 8'd255);
        wait_idle();

        // row counter beyond a height lowered mid-frame: current row becomes the last
        set_reg(REG_LINE_WIDTH, 3);
        set_reg(REG_FRAME_HEIGHT, 4);
        repeat (7) send_pixel(random_pixel());
        wait_idle();
        set_reg(REG_FRAME_HEIGHT, 2);
        n = pixels_to_frame_end();
        repeat (n) send_pixel(random_pixel());
        wait_idle();
    endtask

    task automatic test_extreme_geometry();
        int n;
        // width above the maximum acts as the maximum, height 0 acts as one row
        set_reg(REG_LINE_WIDTH, 2047);
        set_reg(REG_FRAME_HEIGHT, 0);
        repeat (40) send_pixel(random_pixel());
        wait_idle();
        // width 0 acts as one column; the column counter is past it and wraps
        set_reg(REG_LINE_WIDTH, 0);
        n = pixels_to_frame_end();
        repeat (n) send_pixel(random_pixel());
        wait_idle();
        // tallest frame, then height 0 with the row counter past it
        set_reg(REG_FRAME_HEIGHT, 2047);
        repeat (40) send_pixel(random_pixel());
        wait_idle();
        set_reg(REG_FRAME_HEIGHT, 0);
        n = pixels_to_frame_end();
        repeat (n) send_pixel(random_pixel());
        wait_idle();
    endtask

    task automatic test_random_geometry();
        int start_count;
        int new_w;
        int new_h;
        int n;
        start_count = pixel_count;
        while (pixel_count - start_count < 650)
        begin
            case ($urandom_range(0, 9))
                0:       new_w = 0;
                1, 2:    new_w = $urandom_range(17, 80);
                default: new_w = $urandom_range(1, 16);
            endcase
            case ($urandom_range(0, 11))
                0:       new_h = 0;
                1:       new_h = $urandom_range(1025, 2047);
                default: new_h = $urandom_range(1, 6);
            endcase
            if ($urandom_range(0, 3) != 0 && width_change_ok(CFG_W'(new_w)))
                set_reg(REG_LINE_WIDTH, new_w);
            if ($urandom_range(0, 3) != 0)
                set_reg(REG_FRAME_HEIGHT, new_h);

            if ($urandom_range(0, 3) != 0)
                n = pixels_to_frame_end();
            else
                n = $urandom_range(1, 12);
            if (n > 64)
                n = 64;
            repeat (n) send_pixel(random_pixel());
            wait_idle();
        end
    endtask

    task automatic test_steady_stream();
        int n;
        idle_en = 1'b0;
        // close the current frame so the new width starts on row 0
        set_reg(REG_FRAME_HEIGHT, 1);
        n = pixels_to_frame_end();
        repeat (n) send_pixel(random_pixel());
        wait_idle();
        set_reg(REG_LINE_WIDTH, $urandom_range(3, 10));
        set_reg(REG_FRAME_HEIGHT, 3);
        n = 2 * pixels_to_frame_end();
        repeat (n) send_pixel(random_pixel());
        wait_idle();
    endtask

    initial
    begin
        for (int i = 0; i < MAX_WIDTH; i++)
            row_err[i] = '0;
        left_err    = '0;
        up_left_err = '0;
        col_pos     = 0;
        row_pos     = 0;
        cur_width   = LINE_WIDTH_RST;
        cur_height  = FRAME_HEIGHT_RST;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_extreme_geometry();
        test_random_geometry();
        test_steady_stream();

        repeat (10) @(posedge clk);
        $display("Checked %0d pixels over %0d complete frames, %0d register writes,",
                 pixel_count, frame_count, geom_count);
        $display("including degenerate and oversized geometry and mid-frame changes.");
        if (mismatches == 0)
            $display("error_diffusion_dither_core regression: pass");
        else
            $display("error_diffusion_dither_core regression: fail");
        $finish;
    end

endmodule
